>>> hw/rtl/sct_pkg.sv
// Socket connection table: shared types, codes and reset constants.
// Used by every module of the block; depends on nothing.
package sct_pkg;

  localparam int SLOTS_DEFAULT = 16;

  localparam logic [15:0] EPH_FIRST_RESET = 16'd49152;
  localparam logic [15:0] EPH_LAST_RESET  = 16'd65535;
  localparam logic [15:0] NEXT_PORT_RESET = 16'd49152;

  typedef enum logic [3:0] {
    OP_ALLOC       = 4'd0,
    OP_RELEASE     = 4'd1,
    OP_SET_LOCAL   = 4'd2,
    OP_SET_REMOTE  = 4'd3,
    OP_SET_LISTEN  = 4'd4,
    OP_FIND_PORT   = 4'd5,
    OP_FIND_DGRAM  = 4'd6,
    OP_FIND_LISTEN = 4'd7,
    OP_FIND_TUPLE  = 4'd8,
    OP_ALLOC_PORT  = 4'd9
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_USED = 2'd2,
    ST_NONE     = 2'd3
  } status_t;

  typedef enum logic {
    REG_EPH_FIRST = 1'b0,
    REG_EPH_LAST  = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SET,
    S_ASCAN,
    S_FSCAN,
    S_PCAND,
    S_PSCAN,
    S_FIN
  } state_t;

  // input item without op, slot in the low bits
  typedef struct packed {
    logic [15:0] rmt_port;
    logic [31:0] remote_addr;
    logic [15:0] lcl_port;
    logic [31:0] local_addr;
    logic        listening;
    logic        is_stream;
    logic [3:0]  slot;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] port;
    logic [3:0]  found_slot;
    logic        hit;
  } res_t;

  typedef struct packed {
    logic [15:0] rmt_port;
    logic [31:0] remote_addr;
    logic [15:0] lcl_port;
    logic [31:0] local_addr;
    logic        listen;
    logic        stream;
  } entry_t;

  // per-field write enables of the slot store
  typedef struct packed {
    logic stream_we;
    logic listen_we;
    logic local_we;
    logic remote_we;
  } wen_t;

endpackage

>>> hw/rtl/sct_mem.sv
// Slot field store: one write and one registered read port per cycle.
// Depends on sct_pkg.
module sct_mem #(
  parameter int SLOTS = sct_pkg::SLOTS_DEFAULT,
  parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic             clk,
  input  sct_pkg::wen_t    we,
  input  logic [IW-1:0]    waddr,
  input  sct_pkg::entry_t  wdata,
  input  logic [IW-1:0]    raddr,
  output sct_pkg::entry_t  rdata
);

  logic        stream_mem [SLOTS];
  logic        listen_mem [SLOTS];
  logic [47:0] local_mem  [SLOTS];
  logic [47:0] remote_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we.stream_we) begin
      stream_mem[waddr] <= wdata.stream;
    end
    if (we.listen_we) begin
      listen_mem[waddr] <= wdata.listen;
    end
    if (we.local_we) begin
      local_mem[waddr] <= {wdata.lcl_port, wdata.local_addr};
    end
    if (we.remote_we) begin
      remote_mem[waddr] <= {wdata.rmt_port, wdata.remote_addr};
    end
  end

  always_ff @(posedge clk) begin
    rdata <= {remote_mem[raddr][47:32], remote_mem[raddr][31:0],
              local_mem[raddr][47:32], local_mem[raddr][31:0],
              listen_mem[raddr], stream_mem[raddr]};
  end

endmodule

>>> hw/rtl/sct_match.sv
// Shared compare unit: tests one stored slot against the search key.
// Depends on sct_pkg.
module sct_match (
  input  sct_pkg::op_t    mode,
  input  sct_pkg::item_t  key,
  input  sct_pkg::entry_t entry,
  output logic            match
);

  logic port_eq;
  logic local_ok;
  logic remote_ok;

  assign port_eq   = (entry.lcl_port == key.lcl_port);
  // stored local address of zero is a wildcard
  assign local_ok  = port_eq &&
                     ((entry.local_addr == 32'd0) || (entry.local_addr == key.local_addr));
  assign remote_ok = (entry.rmt_port == key.rmt_port) &&
                     (entry.remote_addr == key.remote_addr);

  always_comb begin
    case (mode)
      sct_pkg::OP_FIND_PORT:   match = local_ok;
      sct_pkg::OP_FIND_DGRAM:  match = !entry.stream && local_ok;
      sct_pkg::OP_FIND_LISTEN: match = entry.stream && entry.listen && port_eq;
      sct_pkg::OP_FIND_TUPLE:  match = entry.stream && local_ok && remote_ok;
      sct_pkg::OP_ALLOC_PORT:  match = port_eq;
      default:                 match = 1'b0;
    endcase
  end

endmodule

>>> hw/rtl/sct_seq.sv
// Sequencer: used bits, slot scan, ephemeral port counter and result register.
// Depends on sct_pkg; drives sct_mem and sct_match from the top level.
module sct_seq #(
  parameter int SLOTS = sct_pkg::SLOTS_DEFAULT,
  parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  parameter int CNTW  = $clog2(SLOTS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sct_pkg::op_t     in_op,
  input  sct_pkg::item_t   in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output sct_pkg::res_t    out_res,
  input  logic [15:0]      eph_first,
  input  logic [15:0]      eph_last,
  output sct_pkg::wen_t    mem_we,
  output logic [IW-1:0]    mem_waddr,
  output sct_pkg::entry_t  mem_wdata,
  output logic [IW-1:0]    mem_raddr,
  output sct_pkg::op_t     cmp_mode,
  output sct_pkg::item_t   cmp_key,
  input  logic             cmp_match
);

  sct_pkg::state_t state, state_next;
  sct_pkg::op_t    op, op_next;
  sct_pkg::item_t  item, item_next;
  sct_pkg::res_t   res, res_next;
  sct_pkg::res_t   out_res_next;
  logic            out_valid_next;
  logic [SLOTS-1:0] used, used_next;
  logic [CNTW-1:0] ridx, ridx_next;
  logic [IW-1:0]   cidx, cidx_next;
  logic            cvld, cvld_next;
  logic [15:0]     cand, cand_next;
  logic [16:0]     remaining, remaining_next;
  logic [15:0]     next_port, next_port_next;

  logic [8:0]      slot_w;
  logic [IW-1:0]   slot_idx;
  logic            slot_ok;
  logic [8:0]      ridx_w;
  logic [8:0]      cidx_w;
  logic [IW-1:0]   aidx;
  logic [15:0]     last_eff;
  logic [15:0]     cand_c;
  logic            issue;
  logic            hit_now;
  logic            last_now;

  assign slot_w   = {5'd0, item.slot};
  assign slot_idx = slot_w[IW-1:0];
  assign slot_ok  = (slot_w < 9'(SLOTS)) && used[slot_idx];
  assign ridx_w   = 9'(ridx);
  assign cidx_w   = 9'(cidx);
  assign aidx     = ridx[IW-1:0];
  assign last_eff = (eph_last < eph_first) ? eph_first : eph_last;
  assign cand_c   = ((next_port < eph_first) || (next_port > last_eff)) ? eph_first
                                                                          : next_port;
  assign issue    = (ridx < CNTW'(SLOTS));
  assign hit_now  = cvld && used[cidx] && cmp_match;
  assign last_now = cvld && (cidx == IW'(SLOTS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sct_pkg::S_IDLE;
      used      <= '0;
      out_valid <= 1'b0;
      next_port <= sct_pkg::NEXT_PORT_RESET;
    end else begin
      state     <= state_next;
      used      <= used_next;
      out_valid <= out_valid_next;
      next_port <= next_port_next;
    end
  end

  always_ff @(posedge clk) begin
    op        <= op_next;
    item      <= item_next;
    res       <= res_next;
    out_res   <= out_res_next;
    ridx      <= ridx_next;
    cidx      <= cidx_next;
    cvld      <= cvld_next;
    cand      <= cand_next;
    remaining <= remaining_next;
  end

  always_comb begin
    state_next     = state;
    op_next        = op;
    item_next      = item;
    res_next       = res;
    out_res_next   = out_res;
    out_valid_next = out_valid && !out_ready;
    used_next      = used;
    ridx_next      = ridx;
    cidx_next      = cidx;
    cvld_next      = cvld;
    cand_next      = cand;
    remaining_next = remaining;
    next_port_next = next_port;

    in_ready  = (state == sct_pkg::S_IDLE);
    mem_we    = '0;
    mem_waddr = slot_idx;
    mem_wdata = '0;
    mem_raddr = ridx[IW-1:0];
    cmp_mode  = op;
    cmp_key   = item;
    if (state == sct_pkg::S_PSCAN) begin
      cmp_key.lcl_port = cand;
    end

    case (state)
      sct_pkg::S_IDLE: begin
        if (in_valid) begin
          op_next        = in_op;
          item_next      = in_item;
          res_next       = '0;
          ridx_next      = '0;
          cvld_next      = 1'b0;
          remaining_next = {1'b0, last_eff} - {1'b0, eph_first} + 17'd1;
          case (in_op)
            sct_pkg::OP_ALLOC:       state_next = sct_pkg::S_ASCAN;
            sct_pkg::OP_RELEASE,
            sct_pkg::OP_SET_LOCAL,
            sct_pkg::OP_SET_REMOTE,
            sct_pkg::OP_SET_LISTEN:  state_next = sct_pkg::S_SET;
            sct_pkg::OP_FIND_PORT,
            sct_pkg::OP_FIND_DGRAM,
            sct_pkg::OP_FIND_LISTEN,
            sct_pkg::OP_FIND_TUPLE:  state_next = sct_pkg::S_FSCAN;
            sct_pkg::OP_ALLOC_PORT:  state_next = sct_pkg::S_PCAND;
            default:                 state_next = sct_pkg::S_FIN;
          endcase
        end
      end

      sct_pkg::S_SET: begin
        state_next = sct_pkg::S_FIN;
        if (!slot_ok) begin
          res_next.status = sct_pkg::ST_NOT_USED;
        end else begin
          mem_wdata.local_addr  = item.local_addr;
          mem_wdata.lcl_port    = item.lcl_port;
          mem_wdata.remote_addr = item.remote_addr;
          mem_wdata.rmt_port    = item.rmt_port;
          mem_wdata.listen      = item.listening;
          case (op)
            sct_pkg::OP_RELEASE:    used_next[slot_idx] = 1'b0;
            sct_pkg::OP_SET_LOCAL:  mem_we.local_we = 1'b1;
            sct_pkg::OP_SET_REMOTE: mem_we.remote_we = 1'b1;
            sct_pkg::OP_SET_LISTEN: mem_we.listen_we = 1'b1;
            default: ;
          endcase
        end
      end

      // lowest free slot, one used bit per cycle
      sct_pkg::S_ASCAN: begin
        if (!used[aidx]) begin
          mem_waddr        = aidx;
          mem_we           = '1;
          mem_wdata.stream = item.is_stream;
          used_next[aidx]  = 1'b1;
          res_next.hit        = 1'b1;
          res_next.found_slot = ridx_w[3:0];
          state_next          = sct_pkg::S_FIN;
        end else if (ridx == CNTW'(SLOTS - 1)) begin
          res_next.status = sct_pkg::ST_FULL;
          state_next      = sct_pkg::S_FIN;
        end else begin
          ridx_next = ridx + CNTW'(1);
        end
      end

      // read of slot k overlaps the compare of slot k-1
      sct_pkg::S_FSCAN, sct_pkg::S_PSCAN: begin
        ridx_next = issue ? (ridx + CNTW'(1)) : ridx;
        cvld_next = issue;
        cidx_next = ridx[IW-1:0];
        if (state == sct_pkg::S_FSCAN) begin
          if (hit_now) begin
            res_next.hit        = 1'b1;
            res_next.found_slot = cidx_w[3:0];
            state_next          = sct_pkg::S_FIN;
          end else if (last_now) begin
            res_next.status = sct_pkg::ST_NONE;
            state_next      = sct_pkg::S_FIN;
          end
        end else begin
          if (hit_now) begin
            // candidate taken
            if (remaining == 17'd1) begin
              res_next.status = sct_pkg::ST_NONE;
              state_next      = sct_pkg::S_FIN;
            end else begin
              remaining_next = remaining - 17'd1;
              state_next     = sct_pkg::S_PCAND;
            end
          end else if (last_now) begin
            res_next.hit    = 1'b1;
            res_next.port   = cand;
            state_next      = sct_pkg::S_FIN;
          end
        end
      end

      sct_pkg::S_PCAND: begin
        cand_next      = cand_c;
        next_port_next = (cand_c >= last_eff) ? eph_first : (cand_c + 16'd1);
        ridx_next      = '0;
        cvld_next      = 1'b0;
        if (cand_c == 16'd0) begin
          // port zero never handed out
          if (remaining == 17'd1) begin
            res_next.status = sct_pkg::ST_NONE;
            state_next      = sct_pkg::S_FIN;
          end else begin
            remaining_next = remaining - 17'd1;
          end
        end else begin
          state_next = sct_pkg::S_PSCAN;
        end
      end

      sct_pkg::S_FIN: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          out_res_next   = res;
          state_next     = sct_pkg::S_IDLE;
        end
      end

      default: state_next = sct_pkg::S_IDLE;
    endcase
  end

endmodule

>>> hw/rtl/socket_connection_table_core.sv
// Socket connection table, top level: ports, config registers, submodules.
// Depends on sct_pkg, sct_mem, sct_match and sct_seq.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tuser op, s_tdata item fields
//  m_*       out  m_tvalid/m_tready  m_tdata result
//  cfg_*     in   cfg_we             cfg_index, cfg_wdata
//
// Set/release take a single step; alloc scans the used bits slot by slot; find
// reads and compares the slots in turn, one memory read per cycle, through the
// single compare unit; alloc port scans the slots for each candidate tried (a zero
// candidate is skipped), with up to one candidate per port in the range.
// s_tready is high only while idle; a held result does not block the next item
// until that item finishes. rst is synchronous; the slot store needs no
// clearing pass, so the block is ready right after reset.
module socket_connection_table_core #(
  parameter int SLOTS = sct_pkg::SLOTS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // slot[3:0] is_stream[4] listening[5] local_addr[37:6] lcl_port[53:38]
  // remote_addr[85:54] rmt_port[101:86], zero pad [103:102]
  input  logic [103:0] s_tdata,
  // op[3:0]
  input  logic [3:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // hit[0] found_slot[4:1] port[20:5] status[22:21], zero pad [23]
  output logic [23:0]  m_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_wdata
);

  localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNTW = $clog2(SLOTS + 1);

  logic [15:0]      eph_first;
  logic [15:0]      eph_last;
  sct_pkg::res_t    res;
  sct_pkg::wen_t    mem_we;
  logic [IW-1:0]    mem_waddr;
  logic [IW-1:0]    mem_raddr;
  sct_pkg::entry_t  mem_wdata;
  sct_pkg::entry_t  mem_rdata;
  sct_pkg::op_t     cmp_mode;
  sct_pkg::item_t   cmp_key;
  logic             cmp_match;

  always_ff @(posedge clk) begin
    if (rst) begin
      eph_first <= sct_pkg::EPH_FIRST_RESET;
      eph_last  <= sct_pkg::EPH_LAST_RESET;
    end else if (cfg_we) begin
      case (sct_pkg::reg_idx_t'(cfg_index))
        sct_pkg::REG_EPH_FIRST: eph_first <= cfg_wdata;
        sct_pkg::REG_EPH_LAST:  eph_last  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  sct_seq #(
    .SLOTS (SLOTS),
    .IW    (IW),
    .CNTW  (CNTW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (sct_pkg::op_t'(s_tuser)),
    .in_item   (sct_pkg::item_t'(s_tdata[101:0])),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res),
    .eph_first (eph_first),
    .eph_last  (eph_last),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .cmp_mode  (cmp_mode),
    .cmp_key   (cmp_key),
    .cmp_match (cmp_match)
  );

  sct_mem #(
    .SLOTS (SLOTS),
    .IW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sct_match u_match (
    .mode  (cmp_mode),
    .key   (cmp_key),
    .entry (mem_rdata),
    .match (cmp_match)
  );

  assign m_tdata = {1'b0, res};

endmodule

>>> hw/rtl/sct_checker.sv
// Port-level checks for the socket connection table, bound to the top level.
// Depends on sct_pkg and socket_connection_table_core.
module sct_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // a held result stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // s_tready is low in the cycle after every accepted item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready right after accept");

  // a hit always reports ok status
  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[22:21] == sct_pkg::ST_OK)
    else $error("hit with error status");

  // misses carry no slot and no port
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[20:1] == 20'd0)
    else $error("miss with nonzero slot or port");

  // a granted port never comes with a slot index
  a_port_no_slot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[20:5] != 16'd0 |-> m_tdata[4:1] == 4'd0)
    else $error("port result with slot index");

endmodule

bind socket_connection_table_core sct_checker u_chk (.*);

>>> tb/socket_table_checker.sv
// Checker for the socket connection table: watches the item, result and config
// channels, predicts each result from its own copy of the table, compares.
// Depends on sct_pkg.
module socket_table_checker
  import sct_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [103:0] s_tdata,
  input  logic [3:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [23:0]  m_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_wdata,
  output int           errors,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic        in_use   [SLOTS];
  entry_t      slot_rec [SLOTS];
  logic [15:0] range_first;
  logic [15:0] range_last;
  logic [15:0] port_cursor;
  res_t        answers_due [$];

  // zero stored address is a wildcard
  function automatic bit local_hit(int i, logic [31:0] addr, logic [15:0] lport);
    return slot_rec[i].lcl_port == lport &&
           (slot_rec[i].local_addr == '0 || slot_rec[i].local_addr == addr);
  endfunction

  function automatic bit port_held(logic [15:0] p);
    if (p == '0) return 1'b1;
    for (int i = 0; i < SLOTS; i++)
      if (in_use[i] && slot_rec[i].lcl_port == p) return 1'b1;
    return 1'b0;
  endfunction

  function automatic res_t table_outcome(logic [3:0] op, item_t it);
    res_t        r;
    bit          done;
    bit          m;
    int          span;
    logic [15:0] hi;
    logic [15:0] cand;
    r    = '0;
    done = 1'b0;
    case (op)
      OP_ALLOC: begin
        r.status = ST_FULL;
        for (int i = 0; i < SLOTS; i++)
          if (!done && !in_use[i]) begin
            in_use[i]          = 1'b1;
            slot_rec[i]        = '0;
            slot_rec[i].stream = it.is_stream;
            r.hit        = 1'b1;
            r.found_slot = 4'(i);
            r.status     = ST_OK;
            done         = 1'b1;
          end
      end
      OP_RELEASE, OP_SET_LOCAL, OP_SET_REMOTE, OP_SET_LISTEN: begin
        if (int'(it.slot) >= SLOTS || !in_use[it.slot]) begin
          r.status = ST_NOT_USED;
        end else begin
          case (op)
            OP_RELEASE: begin
              in_use[it.slot]   = 1'b0;
              slot_rec[it.slot] = '0;
            end
            OP_SET_LOCAL: begin
              slot_rec[it.slot].local_addr = it.local_addr;
              slot_rec[it.slot].lcl_port   = it.lcl_port;
            end
            OP_SET_REMOTE: begin
              slot_rec[it.slot].remote_addr = it.remote_addr;
              slot_rec[it.slot].rmt_port    = it.rmt_port;
            end
            default: slot_rec[it.slot].listen = it.listening;
          endcase
        end
      end
      OP_FIND_PORT, OP_FIND_DGRAM, OP_FIND_LISTEN, OP_FIND_TUPLE: begin
        r.status = ST_NONE;
        for (int i = 0; i < SLOTS; i++)
          if (!done && in_use[i]) begin
            case (op)
              OP_FIND_PORT:  m = local_hit(i, it.local_addr, it.lcl_port);
              OP_FIND_DGRAM: m = !slot_rec[i].stream &&
                                 local_hit(i, it.local_addr, it.lcl_port);
              // listener lookup ignores the address
              OP_FIND_LISTEN: m = slot_rec[i].stream && slot_rec[i].listen &&
                                  slot_rec[i].lcl_port == it.lcl_port;
              default: m = slot_rec[i].stream &&
                           local_hit(i, it.local_addr, it.lcl_port) &&
                           slot_rec[i].rmt_port == it.rmt_port &&
                           slot_rec[i].remote_addr == it.remote_addr;
            endcase
            if (m) begin
              r.hit        = 1'b1;
              r.found_slot = 4'(i);
              r.status     = ST_OK;
              done         = 1'b1;
            end
          end
      end
      OP_ALLOC_PORT: begin
        // inverted range collapses to the single first port
        hi       = (range_last < range_first) ? range_first : range_last;
        span     = int'(hi) - int'(range_first) + 1;
        r.status = ST_NONE;
        for (int n = 0; n < span && !done; n++) begin
          cand = port_cursor;
          if (cand < range_first || cand > hi) cand = range_first;
          port_cursor = (cand >= hi) ? range_first : cand + 16'd1;
          if (!port_held(cand)) begin
            r.hit    = 1'b1;
            r.port   = cand;
            r.status = ST_OK;
            done     = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int field_diff(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    res_t got;
    res_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        in_use[i]   = 1'b0;
        slot_rec[i] = '0;
      end
      range_first = EPH_FIRST_RESET;
      range_last  = EPH_LAST_RESET;
      port_cursor = NEXT_PORT_RESET;
      answers_due.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_EPH_FIRST) range_first = cfg_wdata;
        else range_last = cfg_wdata;
      end
      if (m_tvalid && m_tready) begin
        got = res_t'(m_tdata[22:0]);
        if (answers_due.size() == 0) begin
          $error("result item with no request outstanding");
          errors++;
        end else begin
          want = answers_due.pop_front();
          errors += field_diff("hit", want.hit, got.hit) +
                    field_diff("found_slot", want.found_slot, got.found_slot) +
                    field_diff("port", want.port, got.port) +
                    field_diff("status", want.status, got.status);
        end
      end
      if (s_tvalid && s_tready)
        answers_due.push_back(table_outcome(s_tuser, item_t'(s_tdata[101:0])));
    end
    pending = answers_due.size();
  end

endmodule

>>> tb/tb_socket_connection_table_core.sv
// Top of the socket connection table bench: clock, reset, stimulus phases over
// several ephemeral port ranges, output back-pressure and the verdict.
// Depends on sct_pkg, socket_connection_table_core and socket_table_checker.
module tb_socket_connection_table_core;
  timeunit 1ns;
  timeprecision 1ps;
  import sct_pkg::*;

  localparam int SLOTS       = 16;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 400;
  localparam logic [3:0] OP_SPARE_FIRST = 4'd10;
  localparam logic [3:0] OP_SPARE_LAST  = 4'd15;

  logic         clk       = 1'b0;
  logic         rst       = 1'b1;
  logic         s_tvalid  = 1'b0;
  logic         s_tready;
  logic [103:0] s_tdata   = '0;
  logic [3:0]   s_tuser   = '0;
  logic         m_tvalid;
  logic         m_tready  = 1'b0;
  logic [23:0]  m_tdata;
  logic         cfg_we    = 1'b0;
  logic         cfg_index = 1'b0;
  logic [15:0]  cfg_wdata = '0;

  int          errors;
  int          pending;
  int          items_sent = 0;
  int          cycle_cnt  = 0;
  bit          calm       = 1'b0;
  bit          hold_go    = 1'b0;
  bit          hold_done  = 1'b0;
  logic [15:0] port_base  = EPH_FIRST_RESET;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  socket_connection_table_core #(.SLOTS(SLOTS)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  socket_table_checker #(.SLOTS(SLOTS)) table_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin : result_sink
    int held;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        m_tready <= 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(negedge clk);
          held++;
        end
        hold_done = 1'b1;
      end else begin
        m_tready <= calm || ($urandom_range(99) >= 17);
      end
    end
  end

  function automatic item_t mk(logic [3:0] slot, logic strm, logic lst,
                               logic [31:0] la, logic [15:0] lp,
                               logic [31:0] ra, logic [15:0] rp);
    item_t it;
    it.slot        = slot;
    it.is_stream   = strm;
    it.listening   = lst;
    it.local_addr  = la;
    it.lcl_port    = lp;
    it.remote_addr = ra;
    it.rmt_port    = rp;
    return it;
  endfunction

  // small pools so that finds and port skips actually hit
  function automatic logic [15:0] pick_port();
    case ($urandom_range(9))
      0, 1, 2, 3: return port_base + 16'($urandom_range(5));
      4:          return 16'd80;
      5:          return 16'd443;
      6:          return 16'd65535;
      7:          return 16'd0;
      default:    return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(7))
      0, 1:    return 32'h0;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0A00_0001;
      4:       return 32'hC0A8_0001;
      5:       return 32'h0A00_0002;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [3:0] rand_op();
    int unsigned r = $urandom_range(99);
    if (r < 14) return OP_ALLOC;
    if (r < 22) return OP_RELEASE;
    if (r < 36) return OP_SET_LOCAL;
    if (r < 46) return OP_SET_REMOTE;
    if (r < 52) return OP_SET_LISTEN;
    if (r < 62) return OP_FIND_PORT;
    if (r < 70) return OP_FIND_DGRAM;
    if (r < 78) return OP_FIND_LISTEN;
    if (r < 88) return OP_FIND_TUPLE;
    if (r < 97) return OP_ALLOC_PORT;
    return 4'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
  endfunction

  // entered and left at a falling edge; valid stays up between back-to-back items
  task automatic send(logic [3:0] op, item_t it);
    if (!calm && $urandom_range(99) < 17) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {2'b00, it};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic run_random(int n);
    repeat (n)
      send(rand_op(), mk(4'($urandom_range(15)), 1'($urandom_range(1)),
                         1'($urandom_range(1)), pick_addr(), pick_port(),
                         pick_addr(), pick_port()));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_range(logic [15:0] first, logic [15:0] last);
    cfg_we    <= 1'b1;
    cfg_index <= REG_EPH_FIRST;
    cfg_wdata <= first;
    @(negedge clk);
    cfg_index <= REG_EPH_LAST;
    cfg_wdata <= last;
    @(negedge clk);
    cfg_we    <= 1'b0;
    port_base = first;
  endtask

  initial begin : stimulus
    item_t blank;
    blank = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // empty table, wildcard address, type filters, port skip, spare opcodes
    send(OP_FIND_PORT, mk(0, 0, 0, 32'h0, 16'd80, 32'h0, 16'd0));
    send(OP_RELEASE, blank);
    send(OP_SET_LOCAL, mk(15, 0, 0, 32'h0A00_0001, 16'd80, 32'h0, 16'd0));
    send(OP_ALLOC, mk(0, 1, 0, 32'h0, 16'd0, 32'h0, 16'd0));
    send(OP_ALLOC, mk(0, 0, 0, 32'h0, 16'd0, 32'h0, 16'd0));
    send(OP_SET_LOCAL, mk(0, 0, 0, 32'h0, 16'd80, 32'h0, 16'd0));
    send(OP_SET_LOCAL, mk(1, 0, 0, 32'hFFFF_FFFF, 16'd65535, 32'h0, 16'd0));
    send(OP_SET_REMOTE, mk(0, 0, 0, 32'h0, 16'd0, 32'hFFFF_FFFF, 16'd65535));
    send(OP_SET_LISTEN, mk(0, 0, 1, 32'h0, 16'd0, 32'h0, 16'd0));
    send(OP_FIND_PORT, mk(0, 0, 0, 32'h0A00_0001, 16'd80, 32'h0, 16'd0));
    send(OP_FIND_DGRAM, mk(0, 0, 0, 32'hFFFF_FFFF, 16'd65535, 32'h0, 16'd0));
    send(OP_FIND_DGRAM, mk(0, 0, 0, 32'h0, 16'd65535, 32'h0, 16'd0));
    send(OP_FIND_LISTEN, mk(0, 0, 0, 32'h0102_0304, 16'd80, 32'h0, 16'd0));
    send(OP_FIND_TUPLE, mk(0, 0, 0, 32'h0102_0304, 16'd80, 32'hFFFF_FFFF, 16'd65535));
    send(OP_FIND_TUPLE, mk(0, 0, 0, 32'h0102_0304, 16'd80, 32'hFFFF_FFFF, 16'd65534));
    send(OP_SET_LISTEN, mk(1, 0, 1, 32'h0, 16'd0, 32'h0, 16'd0));
    send(OP_FIND_LISTEN, mk(0, 0, 0, 32'h0, 16'd65535, 32'h0, 16'd0));
    send(OP_SET_LOCAL, mk(0, 0, 0, 32'h0, EPH_FIRST_RESET, 32'h0, 16'd0));
    send(OP_ALLOC_PORT, blank);
    send(OP_SPARE_LAST, '1);
    send(OP_RELEASE, blank);
    send(OP_SET_REMOTE, mk(0, 0, 0, 32'h0, 16'd0, 32'h0A00_0001, 16'd7));
    send(OP_SPARE_FIRST, blank);
    run_random(280);

    // widest range; long output hold-off in the middle
    drain();
    set_range(16'd1, 16'd65535);
    run_random(60);
    hold_go = 1'b1;
    run_random(200);

    // four-port range: fill the table, occupy every port, exhaust the allocator
    drain();
    set_range(16'd1000, 16'd1003);
    repeat (17) send(OP_ALLOC, mk(0, 1'($urandom_range(1)), 0, 32'h0, 16'd0, 32'h0, 16'd0));
    for (int i = 0; i < 4; i++)
      send(OP_SET_LOCAL, mk(4'(i), 0, 0, 32'h0, 16'(1000 + i), 32'h0, 16'd0));
    send(OP_ALLOC_PORT, blank);
    send(OP_ALLOC_PORT, blank);
    send(OP_RELEASE, mk(2, 0, 0, 32'h0, 16'd0, 32'h0, 16'd0));
    send(OP_ALLOC_PORT, blank);
    run_random(220);

    // range starting at zero: port zero is never handed out
    drain();
    set_range(16'd0, 16'd2);
    repeat (4) send(OP_ALLOC_PORT, blank);
    run_random(60);

    // single top port, no idling on either side
    drain();
    calm = 1'b1;
    set_range(16'd65535, 16'd65535);
    run_random(150);
    calm = 1'b0;

    // last below first
    drain();
    set_range(16'd60000, 16'd100);
    run_random(150);

    drain();
    set_range(EPH_FIRST_RESET, EPH_LAST_RESET);
    run_random(100);

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Ran %0d items through alloc, release, set, find and port allocation", items_sent);
    $display("over seven port ranges, with a %0d-cycle output stall.", HOLD_CYCLES);
    if (errors == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/sct_pkg.sv
hw/rtl/sct_mem.sv
hw/rtl/sct_match.sv
hw/rtl/sct_seq.sv
hw/rtl/socket_connection_table_core.sv
hw/rtl/sct_checker.sv
tb/socket_table_checker.sv
tb/tb_socket_connection_table_core.sv
